// ===== sv/rmbd_pkg.sv =====
// Shared types and constants of the multi-bulk command log deframer.
package rmbd_pkg;

  // Marker, terminator and digit bytes of the framing
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PARAM_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PARAM_COUNT  = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  // Result kinds
  typedef enum logic [1:0] {
    EV_PAYLOAD   = 2'd0,
    EV_PARAM_END = 2'd1,
    EV_ERROR     = 2'd2,
    EV_STATUS    = 2'd3
  } ev_kind_e;

  // Parser phases, one-hot
  typedef enum logic [11:0] {
    PH_STAR        = 12'b0000_0000_0001,
    PH_COUNT_FIRST = 12'b0000_0000_0010,
    PH_COUNT_MORE  = 12'b0000_0000_0100,
    PH_COUNT_LF    = 12'b0000_0000_1000,
    PH_DOLLAR      = 12'b0000_0001_0000,
    PH_LEN_FIRST   = 12'b0000_0010_0000,
    PH_LEN_MORE    = 12'b0000_0100_0000,
    PH_LEN_LF      = 12'b0000_1000_0000,
    PH_PAYLOAD     = 12'b0001_0000_0000,
    PH_TRAIL1      = 12'b0010_0000_0000,
    PH_TRAIL2      = 12'b0100_0000_0000,
    PH_ERROR       = 12'b1000_0000_0000
  } phase_e;

  // One result item
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  payload_byte;
    logic [7:0]  param_index;
    logic [15:0] param_length;
    logic        last_param;
    logic        file_done;
    logic        file_ok;
  } result_t;

endpackage

// ===== sv/resp_multibulk_deframer.sv =====
// Multi-bulk command log deframer: splits a byte stream into parameters and events.
//
// Usage:
//   s_axis_*  : one log byte per transaction; tlast marks the final byte of the log.
//   m_axis_*  : at most one result per input byte; tuser carries the event kind
//               (payload byte, parameter end, parse error, file status) and tlast
//               marks the result of the final byte.
//   cfg_*     : register writes (max parameter length, max parameter count);
//               always ready, write only while the block is idle.
// Each result is registered in the output register, or in the skid stage while it is held.
// Throughput: one byte per cycle while the skid stage is empty; each byte gets one state update and one
//   decimal multiply-accumulate between the parser registers.
// Stall: the output register plus a one-entry skid stage absorb one result while
//   m_axis_tready is low; s_axis_tready drops only once the skid stage is full.
// Reset: rst_ni clears the parser, empties the output stages and restores both
//   limits to their maximum. The flagged final byte returns the parser to its
//   reset state but keeps the configured limits.
module resp_multibulk_deframer
  import rmbd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream; tdata: [7:0] in_byte; tlast: end_of_file
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Result stream; tdata: [7:0] payload_byte, [15:8] param_index,
  // [31:16] param_length, [32] last_param, [33] file_ok, [39:34] zero
  // tuser: [1:0] event_kind; tlast: file_done
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned ACC_W = LENGTH_BITS + 1;
  localparam int unsigned MUL_W = ACC_W + 4;
  localparam logic [MUL_W-1:0] ACC_CAP = MUL_W'(1) << LENGTH_BITS;
  localparam logic [32:0] LEN_MASK_W = (33'(1) << LENGTH_BITS) - 33'(1);
  localparam logic [32:0] CNT_MASK_W = (33'(1) << COUNT_BITS) - 33'(1);

  // Configuration registers
  logic [15:0] max_len_q;
  logic [7:0]  max_cnt_q;

  // Parser state
  phase_e                 phase_q, phase_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [COUNT_BITS-1:0]  target_q, target_d;
  logic [COUNT_BITS-1:0]  seen_q, seen_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [LENGTH_BITS-1:0] cur_len_q, cur_len_d;
  logic                   error_q, error_d;
  logic                   complete_q, complete_d;

  // Output register and skid stage
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  logic       in_accept;
  logic       pop;
  logic       push;
  logic [7:0] in_byte;
  logic       eof;
  logic       is_digit;
  logic [MUL_W-1:0] acc_mul;
  logic [ACC_W-1:0] acc_sat;
  logic [32:0] acc_wide;
  logic [31:0] seen_ext;
  logic [31:0] len_ext;
  logic        is_last;
  logic        err;
  logic        ev_valid;
  result_t     ev;

  assign in_byte   = s_axis_tdata[7:0];
  assign eof       = s_axis_tlast;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign pop       = out_valid_q && m_axis_tready;
  assign push      = in_accept && ev_valid;

  assign s_axis_tready = !skid_valid_q;
  assign cfg_ready_o   = 1'b1;

  // Decimal accumulate with saturation at the cap
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign acc_mul  = (MUL_W'(acc_q) << 3) + (MUL_W'(acc_q) << 1)
                  + MUL_W'(in_byte[3:0]);
  assign acc_sat  = (acc_mul > ACC_CAP) ? ACC_CAP[ACC_W-1:0] : acc_mul[ACC_W-1:0];
  assign acc_wide = 33'(acc_q);

  // Fields shown for payload and parameter end results
  assign seen_ext = 32'(seen_q);
  assign len_ext  = 32'(cur_len_q);
  assign is_last  = ((COUNT_BITS+1)'(seen_q) + (COUNT_BITS+1)'(1))
                    == (COUNT_BITS+1)'(target_q);

  // Advance the parser by one byte
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    target_d   = target_q;
    seen_d     = seen_q;
    left_d     = left_q;
    cur_len_d  = cur_len_q;
    error_d    = error_q;
    complete_d = complete_q;
    err        = 1'b0;
    ev_valid   = 1'b0;
    ev         = '0;
    ev.kind    = EV_PAYLOAD;

    case (phase_q)
      PH_STAR: begin
        if (in_byte == CHAR_STAR) begin
          complete_d = 1'b0;
          acc_d      = '0;
          phase_d    = PH_COUNT_FIRST;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_FIRST: begin
        if (is_digit) begin
          acc_d   = acc_sat;
          phase_d = PH_COUNT_MORE;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_FIRST: begin
        if (is_digit) begin
          acc_d   = acc_sat;
          phase_d = PH_LEN_MORE;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_MORE: begin
        if (is_digit) begin
          acc_d = acc_sat;
        end else if (in_byte == CHAR_CR) begin
          if (acc_wide == '0 || acc_wide > 33'(max_cnt_q) || acc_wide > CNT_MASK_W) begin
            err = 1'b1;
          end else begin
            target_d = acc_wide[COUNT_BITS-1:0];
            seen_d   = '0;
            phase_d  = PH_COUNT_LF;
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_LF: begin
        if (in_byte == CHAR_LF) phase_d = PH_DOLLAR;
        else err = 1'b1;
      end
      PH_DOLLAR: begin
        if (in_byte == CHAR_DOLLAR) begin
          acc_d   = '0;
          phase_d = PH_LEN_FIRST;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        if (is_digit) begin
          acc_d = acc_sat;
        end else if (in_byte == CHAR_CR) begin
          if (acc_wide > 33'(max_len_q) || acc_wide > LEN_MASK_W) begin
            err = 1'b1;
          end else begin
            cur_len_d = acc_wide[LENGTH_BITS-1:0];
            phase_d   = PH_LEN_LF;
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (in_byte == CHAR_LF) begin
          left_d  = cur_len_q;
          phase_d = (cur_len_q == '0) ? PH_TRAIL1 : PH_PAYLOAD;
        end else begin
          err = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        ev_valid        = 1'b1;
        ev.kind         = EV_PAYLOAD;
        ev.payload_byte = in_byte;
        ev.param_index  = seen_ext[7:0];
        ev.param_length = len_ext[15:0];
        ev.last_param   = is_last;
        left_d          = (left_q == '0) ? '0 : left_q - LENGTH_BITS'(1);
        if (left_d == '0) phase_d = PH_TRAIL1;
      end
      PH_TRAIL1: begin
        phase_d = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        ev_valid        = 1'b1;
        ev.kind         = EV_PARAM_END;
        ev.param_index  = seen_ext[7:0];
        ev.param_length = len_ext[15:0];
        ev.last_param   = is_last;
        seen_d          = seen_q + COUNT_BITS'(1);
        if (seen_d == target_q) begin
          complete_d = 1'b1;
          phase_d    = PH_STAR;
        end else begin
          phase_d = PH_DOLLAR;
        end
      end
      PH_ERROR: begin
        // drop bytes until the end of the log
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // Latch a single parse error
    if (err) begin
      error_d    = 1'b1;
      complete_d = 1'b0;
      phase_d    = PH_ERROR;
      ev_valid   = 1'b1;
      ev         = '0;
      ev.kind    = EV_ERROR;
    end

    // Report file status on the final byte and clear the parser
    if (eof) begin
      if (!ev_valid) begin
        ev      = '0;
        ev.kind = EV_STATUS;
      end
      ev_valid     = 1'b1;
      ev.file_done = 1'b1;
      ev.file_ok   = !error_d && complete_d && (phase_d == PH_STAR);
      phase_d    = PH_STAR;
      acc_d      = '0;
      target_d   = '0;
      seen_d     = '0;
      left_d     = '0;
      cur_len_d  = '0;
      error_d    = 1'b0;
      complete_d = 1'b0;
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_STAR;
      acc_q      <= '0;
      target_q   <= '0;
      seen_q     <= '0;
      left_q     <= '0;
      cur_len_q  <= '0;
      error_q    <= 1'b0;
      complete_q <= 1'b0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      target_q   <= target_d;
      seen_q     <= seen_d;
      left_q     <= left_d;
      cur_len_q  <= cur_len_d;
      error_q    <= error_d;
      complete_q <= complete_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 16'hFFFF;
      max_cnt_q <= 8'hFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_PARAM_LENGTH: max_len_q <= cfg_data_i;
        CFG_MAX_PARAM_COUNT:  max_cnt_q <= cfg_data_i[7:0];
        default: begin
          // ignore writes beyond the register list
        end
      endcase
    end
  end

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output stage data
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= ev;
      else out_q <= ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.file_done;
  assign m_axis_tdata  = {6'b0, out_q.file_ok, out_q.last_param, out_q.param_length,
                          out_q.param_index, out_q.payload_byte};

  // A full skid stage always sits behind a valid output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // A latched error parks the parser in the error phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |-> (phase_q == PH_ERROR))
    else $error("error latched outside the error phase");

  // Parameters seen never pass the declared count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= target_q)
    else $error("parameter index ran past the declared count");

  // Draining the output register refills it from a full skid stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready) |=> (out_valid_q && !skid_valid_q))
    else $error("skid stage did not move into the output register");

endmodule

// ===== tb/sv/resp_multibulk_deframer_tb.sv =====
// Self-checking testbench for the multi-bulk command log deframer with a built-in predictor.
module resp_multibulk_deframer_tb
  import rmbd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned ACC_SAT     = 1 << LENGTH_BITS;
  localparam int unsigned LEN_MAX     = ACC_SAT - 1;
  localparam int unsigned CNT_MAX     = (1 << COUNT_BITS) - 1;
  localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
  localparam logic [7:0]  CHAR_PLUS   = 8'h2B;

  // Shapes of generated commands
  typedef enum int unsigned {
    CMD_CLEAN,
    CMD_AT_LIMIT,
    CMD_COUNT_OVER,
    CMD_LEN_OVER
  } cmd_shape_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  resp_multibulk_deframer #(
    .LENGTH_BITS(LENGTH_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predicted parser state and limit registers
  phase_e      ph;
  logic [16:0] num_acc;
  logic [7:0]  target;
  logic [7:0]  seen;
  logic [15:0] left;
  logic [15:0] cur_len;
  bit          err_seen;
  bit          cmd_done;
  logic [15:0] lim_len;
  logic [7:0]  lim_cnt;

  result_t     expected_events[$];
  logic [7:0]  log_buf[$];
  int unsigned bytes_parsed = 0;
  int unsigned fail_count   = 0;
  int unsigned rx_wait      = 0;
  bit          no_idle      = 1'b0;

  function automatic void clear_parser();
    ph       = PH_STAR;
    num_acc  = '0;
    target   = '0;
    seen     = '0;
    left     = '0;
    cur_len  = '0;
    err_seen = 1'b0;
    cmd_done = 1'b0;
  endfunction

  // Decimal accumulate, saturating one past the largest length
  function automatic logic [16:0] acc_next(input logic [7:0] b);
    int unsigned v;
    v = num_acc * 10 + (b - CHAR_ZERO);
    return (v > ACC_SAT) ? 17'(ACC_SAT) : 17'(v);
  endfunction

  // Advance the predicted parser by one byte; return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, input logic eof,
                                      output result_t res);
    bit hit;
    bit bad;
    bit digit;
    hit   = 1'b0;
    bad   = 1'b0;
    res   = '0;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    case (ph)
      PH_STAR: begin
        if (b == CHAR_STAR) begin
          cmd_done = 1'b0;
          num_acc  = '0;
          ph       = PH_COUNT_FIRST;
        end else bad = 1'b1;
      end
      PH_COUNT_FIRST, PH_LEN_FIRST: begin
        if (digit) begin
          num_acc = acc_next(b);
          ph = (ph == PH_COUNT_FIRST) ? PH_COUNT_MORE : PH_LEN_MORE;
        end else bad = 1'b1;
      end
      PH_COUNT_MORE: begin
        if (digit) begin
          num_acc = acc_next(b);
        end else if (b == CHAR_CR) begin
          if (num_acc == 0 || num_acc > lim_cnt || num_acc > CNT_MAX) begin
            bad = 1'b1;
          end else begin
            target = num_acc[7:0];
            seen   = '0;
            ph     = PH_COUNT_LF;
          end
        end else bad = 1'b1;
      end
      PH_COUNT_LF: begin
        if (b == CHAR_LF) ph = PH_DOLLAR;
        else bad = 1'b1;
      end
      PH_DOLLAR: begin
        if (b == CHAR_DOLLAR) begin
          num_acc = '0;
          ph      = PH_LEN_FIRST;
        end else bad = 1'b1;
      end
      PH_LEN_MORE: begin
        if (digit) begin
          num_acc = acc_next(b);
        end else if (b == CHAR_CR) begin
          if (num_acc > lim_len || num_acc > LEN_MAX) begin
            bad = 1'b1;
          end else begin
            cur_len = num_acc[15:0];
            ph      = PH_LEN_LF;
          end
        end else bad = 1'b1;
      end
      PH_LEN_LF: begin
        if (b == CHAR_LF) begin
          left = cur_len;
          ph   = (left == 0) ? PH_TRAIL1 : PH_PAYLOAD;
        end else bad = 1'b1;
      end
      PH_PAYLOAD: begin
        hit              = 1'b1;
        res.kind         = EV_PAYLOAD;
        res.payload_byte = b;
        res.param_index  = seen;
        res.param_length = cur_len;
        res.last_param   = ({1'b0, seen} + 9'd1 == {1'b0, target});
        left             = left - 16'd1;
        if (left == 0) ph = PH_TRAIL1;
      end
      PH_TRAIL1: ph = PH_TRAIL2;
      PH_TRAIL2: begin
        hit              = 1'b1;
        res.kind         = EV_PARAM_END;
        res.param_index  = seen;
        res.param_length = cur_len;
        res.last_param   = ({1'b0, seen} + 9'd1 == {1'b0, target});
        seen             = seen + 8'd1;
        if (seen == target) begin
          cmd_done = 1'b1;
          ph       = PH_STAR;
        end else begin
          ph = PH_DOLLAR;
        end
      end
      default: ;
    endcase

    // Latch a framing error once
    if (bad) begin
      err_seen = 1'b1;
      cmd_done = 1'b0;
      ph       = PH_ERROR;
      res.kind = EV_ERROR;
      hit      = 1'b1;
    end

    // Report file status on the final byte, then restart the parser
    if (eof) begin
      if (!hit) res.kind = EV_STATUS;
      hit           = 1'b1;
      res.file_done = 1'b1;
      res.file_ok   = !err_seen && cmd_done && (ph == PH_STAR);
      clear_parser();
    end
    return hit;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic string describe_event(input result_t r);
    return $sformatf("kind=%0d byte=%02h idx=%0d len=%0d last=%0b done=%0b ok=%0b",
                     r.kind, r.payload_byte, r.param_index, r.param_length,
                     r.last_param, r.file_done, r.file_ok);
  endfunction

  // Compare one result transaction with the oldest expectation
  task automatic check_event();
    result_t want;
    result_t got;
    got.kind         = ev_kind_e'(m_axis_tuser);
    got.payload_byte = m_axis_tdata[7:0];
    got.param_index  = m_axis_tdata[15:8];
    got.param_length = m_axis_tdata[31:16];
    got.last_param   = m_axis_tdata[32];
    got.file_ok      = m_axis_tdata[33];
    got.file_done    = m_axis_tlast;
    if (expected_events.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result with nothing expected: %s", $realtime, describe_event(got));
    end else begin
      want = expected_events.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                   describe_event(want), describe_event(got));
      end
    end
  endtask

  // Check each result and stall the output side for a random count after it
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_event();
      rx_wait = draw_wait();
      if (rx_wait != 0) m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      rx_wait--;
      if (rx_wait == 0) m_axis_tready <= 1'b1;
    end
  end

  // Send one log byte; valid stays high when the next byte follows without a gap
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    result_t     res;
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    if (ph != PH_ERROR || eof) bytes_parsed++;
    if (deframe_byte(b, eof, res)) expected_events = {expected_events, res};
  endtask

  task automatic send_log();
    foreach (log_buf[i]) send_byte(log_buf[i], i == log_buf.size() - 1);
  endtask

  // Hold the input until every expected result is out, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both limit registers back to back; upper count bits carry junk
  task automatic write_limits(input logic [15:0] len_lim, input logic [7:0] cnt_lim);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MAX_PARAM_LENGTH;
    cfg_data_i  <= len_lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    lim_len = len_lim;
    cfg_index_i <= CFG_MAX_PARAM_COUNT;
    cfg_data_i  <= {junk, cnt_lim};
    do @(posedge clk_i); while (!cfg_ready_o);
    lim_cnt = cnt_lim;
    cfg_valid_i <= 1'b0;
  endtask

  // Log builders
  function automatic void add_byte(input logic [7:0] b);
    log_buf = {log_buf, b};
  endfunction

  function automatic void add_crlf();
    log_buf = {log_buf, CHAR_CR, CHAR_LF};
  endfunction

  function automatic void add_number(input int unsigned value);
    logic [7:0]  digits[$];
    int unsigned v;
    v = value;
    do begin
      digits.push_front(CHAR_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0) digits.push_front(CHAR_ZERO);
    foreach (digits[i]) log_buf = {log_buf, digits[i]};
  endfunction

  function automatic void add_nines(input int unsigned n);
    repeat (n) log_buf = {log_buf, CHAR_NINE};
  endfunction

  function automatic int unsigned pick_len();
    int unsigned cap;
    cap = (lim_len < 8) ? lim_len : 8;
    if ($urandom_range(0, 9) == 0) cap = (lim_len < 40) ? lim_len : 40;
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [7:0] pick_bad_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_MINUS;
      1: return CHAR_PLUS;
      2: return CHAR_CR;
      3: return CHAR_LF;
      4: return CHAR_STAR;
      5: return CHAR_DOLLAR;
      6: return CHAR_ZERO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append one command; return 1 when the log must end right here
  function automatic bit add_command(input cmd_shape_e shape);
    int unsigned cnt;
    int unsigned len;
    int unsigned n_emit;
    bit          cut;
    cut = 1'b0;
    cnt = $urandom_range(1, (lim_cnt < 4) ? lim_cnt : 4);
    if (shape == CMD_AT_LIMIT) cnt = lim_cnt;
    add_byte(CHAR_STAR);
    if (shape == CMD_COUNT_OVER) begin
      if ($urandom_range(0, 1)) add_nines($urandom_range(6, 12));
      else add_number(int'(lim_cnt) + 1);
      add_crlf();
      return 1'b0;
    end
    add_number(cnt);
    add_crlf();
    n_emit = cnt;
    if (n_emit > 4) begin
      n_emit = $urandom_range(1, 3);
      cut    = 1'b1;
    end
    for (int i = 0; i < n_emit; i++) begin
      add_byte(CHAR_DOLLAR);
      if (shape == CMD_LEN_OVER) begin
        if ($urandom_range(0, 1)) add_nines($urandom_range(6, 12));
        else add_number(int'(lim_len) + 1);
        add_crlf();
        return 1'b0;
      end
      len = (shape == CMD_AT_LIMIT) ? lim_len : pick_len();
      add_number(len);
      add_crlf();
      // Truncate inside a long payload
      if (len > 40) begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
        return 1'b1;
      end
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      // Trailing pair is skipped unchecked, so vary it
      if ($urandom_range(0, 3) != 0) add_crlf();
      else repeat (2) add_byte(8'($urandom_range(0, 255)));
    end
    return cut;
  endfunction

  // Build one log: mostly well-formed commands, some broken, cut short or noise
  function automatic void build_log();
    int unsigned pick;
    int unsigned ncmd;
    int unsigned keep;
    bit          cut;
    cmd_shape_e  shape;
    log_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 96) begin
      if ($urandom_range(0, 1)) add_byte(CHAR_STAR);
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    ncmd = $urandom_range(1, 3);
    cut  = 1'b0;
    for (int i = 0; i < ncmd && !cut; i++) begin
      shape = CMD_CLEAN;
      if (i == ncmd - 1) begin
        if (pick >= 80 && pick < 86) shape = CMD_COUNT_OVER;
        else if (pick >= 86 && pick < 92) shape = CMD_LEN_OVER;
        else if (pick >= 92) shape = CMD_AT_LIMIT;
      end
      cut = add_command(shape);
    end
    // Bytes after an over-limit error are ignored until the final one
    if (pick >= 80 && pick < 92)
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
    if (pick >= 65 && pick < 75) begin
      log_buf[$urandom_range(0, log_buf.size() - 1)] = pick_bad_byte();
    end else if (pick >= 75 && pick < 80) begin
      keep = $urandom_range(1, log_buf.size());
      while (log_buf.size() > keep) void'(log_buf.pop_back());
    end
  endfunction

  // Run random logs under one pair of limits
  task automatic run_phase(input logic [15:0] len_lim, input logic [7:0] cnt_lim,
                           input int unsigned quota);
    int unsigned goal;
    drain_results();
    write_limits(len_lim, cnt_lim);
    goal = bytes_parsed + quota;
    while (bytes_parsed < goal) begin
      no_idle = ($urandom_range(0, 4) == 0);
      build_log();
      send_log();
    end
  endtask

  // Short logs at reset limits: zero length, extreme payload bytes, zero count,
  // wrong marker on the final byte
  task automatic test_directed_frames();
    no_idle = 1'b0;
    log_buf.delete();
    add_byte(CHAR_STAR); add_byte(CHAR_ZERO + 8'd1); add_crlf();
    add_byte(CHAR_DOLLAR); add_byte(CHAR_ZERO); add_crlf();
    add_crlf();
    send_log();
    log_buf.delete();
    add_byte(CHAR_STAR); add_byte(CHAR_ZERO + 8'd1); add_crlf();
    add_byte(CHAR_DOLLAR); add_byte(CHAR_ZERO + 8'd2); add_crlf();
    add_byte(8'hFF); add_byte(8'h00); add_crlf();
    send_log();
    log_buf.delete();
    add_byte(CHAR_STAR); add_byte(CHAR_ZERO); add_crlf();
    send_log();
    log_buf.delete();
    add_byte(CHAR_DOLLAR);
    send_log();
  endtask

  // Smallest and largest limits, alone and mixed
  task automatic test_limit_extremes();
    run_phase(16'd1, 8'd1, 275);
    run_phase(16'hFFFF, 8'hFF, 275);
    run_phase(16'd1, 8'hFF, 275);
    run_phase(16'hFFFF, 8'd1, 275);
  endtask

  // Moderate and random limits
  task automatic test_random_limits();
    run_phase(16'd16, 8'd3, 275);
    run_phase(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)), 275);
  endtask

  initial begin
    clear_parser();
    lim_len = 16'hFFFF;
    lim_cnt = 8'hFF;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_frames();
    test_limit_extremes();
    test_random_limits();
    drain_results();
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rmbd_pkg.sv
sv/resp_multibulk_deframer.sv
tb/sv/resp_multibulk_deframer_tb.sv
